### rtl/rgb_color_space_converter_defines.svh
// ---------------------------------------------------------------------------
// RGB color space converter assertion macros
// Shared macros for the concurrent checks of the converter.
// ---------------------------------------------------------------------------
`ifndef RGB_COLOR_SPACE_CONVERTER_DEFINES_SVH
`define RGB_COLOR_SPACE_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CSC_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CSC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rgbcsc_pkg.sv
// ---------------------------------------------------------------------------
// RGB color space converter package
// Shared codes, widths and pipeline payload types.
// ---------------------------------------------------------------------------
package rgbcsc_pkg;

  localparam logic [1:0] SpaceHsv  = 2'd0;
  localparam logic [1:0] SpaceHsl  = 2'd1;
  localparam logic [1:0] SpaceCmyk = 2'd2;

  localparam int NumLanes = 4;
  localparam int RemW     = 17;  // dividend up to 360*255 + 127
  localparam int DsW      = 16;  // 8-bit divisor pre-shifted by QuoW-1
  localparam int QuoW     = 9;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DsW-1:0]  ds;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef lane_t [NumLanes-1:0] lanes_t;

endpackage

### rtl/rgbcsc_prep.sv
// ---------------------------------------------------------------------------
// Converter front end
// Two stages: channel max/min, then per-lane dividend and divisor set-up.
// ---------------------------------------------------------------------------
module rgbcsc_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic [1:0]           output_space,
  output logic                 out_valid,
  output rgbcsc_pkg::lanes_t   out_lanes
);
  import rgbcsc_pkg::*;

  logic       a_valid;
  logic [7:0] a_r, a_g, a_b, a_mx, a_mn;
  logic [7:0] mx_c, mn_c;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= red;
      a_g  <= green;
      a_b  <= blue;
      a_mx <= mx_c;
      a_mn <= mn_c;
    end
  end

  // stage B: numerators n with rounding offset floor(D/2) folded in
  logic [7:0]      d;
  logic [8:0]      sum;
  logic [8:0]      sum_inv;
  logic [7:0]      hsl_den;
  logic [10:0]     hue_t;
  logic [RemW-1:0] hue_n;
  lanes_t          lanes_next;

  function automatic lane_t mk_lane(logic [RemW-1:0] x, logic [7:0] dv);
    lane_t l;
    l.rem = x;
    l.ds  = {dv, 8'd0};
    l.quo = '0;
    return l;
  endfunction

  function automatic logic [RemW-1:0] pct(logic [7:0] n, logic [7:0] dv);
    return RemW'(n) * RemW'(100) + RemW'(dv[7:1]);
  endfunction

  always_comb begin
    d       = a_mx - a_mn;
    sum     = {1'b0, a_mx} + {1'b0, a_mn};
    sum_inv = 9'd510 - sum;
    hsl_den = (sum < sum_inv) ? sum[7:0] : sum_inv[7:0];
    hue_t   = '0;
    hue_n   = '0;
    if (a_mx == a_r) begin
      if (a_g >= a_b) begin
        hue_n = RemW'(a_g - a_b) * RemW'(60);
      end else begin
        hue_n = RemW'(d) * RemW'(360) - RemW'(a_b - a_g) * RemW'(60);
      end
    end else if (a_mx == a_g) begin
      hue_t = {2'b0, d, 1'b0} + {3'b0, a_b} - {3'b0, a_r};
      hue_n = RemW'(hue_t) * RemW'(60);
    end else begin
      hue_t = {1'b0, d, 2'b0} + {3'b0, a_r} - {3'b0, a_g};
      hue_n = RemW'(hue_t) * RemW'(60);
    end
    if (d != 8'd0) hue_n = hue_n + RemW'(d[7:1]);

    for (int i = 0; i < NumLanes; i++) lanes_next[i] = mk_lane('0, 8'd1);

    unique case (output_space)
      SpaceHsv: begin
        if (d != 8'd0)    lanes_next[0] = mk_lane(hue_n, d);
        if (a_mx != 8'd0) lanes_next[1] = mk_lane(pct(d, a_mx), a_mx);
        lanes_next[2] = mk_lane(pct(a_mx, 8'd255), 8'd255);
      end
      SpaceHsl: begin
        if (d != 8'd0) lanes_next[0] = mk_lane(hue_n, d);
        if (sum != 9'd0 && sum != 9'd510) begin
          lanes_next[1] = mk_lane(pct(d, hsl_den), hsl_den);
        end
        // round(100*sum/510) = floor((50*sum + 127) / 255)
        lanes_next[2] = mk_lane(RemW'(sum) * RemW'(50) + RemW'(127), 8'd255);
      end
      SpaceCmyk: begin
        if (a_mx != 8'd0) begin
          lanes_next[0] = mk_lane(pct(a_mx - a_r, a_mx), a_mx);
          lanes_next[1] = mk_lane(pct(a_mx - a_g, a_mx), a_mx);
          lanes_next[2] = mk_lane(pct(a_mx - a_b, a_mx), a_mx);
        end
        lanes_next[3] = mk_lane(pct(8'd255 - a_mx, 8'd255), 8'd255);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_lanes <= lanes_next;
  end

endmodule

### rtl/rgbcsc_div_step.sv
// ---------------------------------------------------------------------------
// Divider step
// One restoring-division bit for all four lanes, registered.
// ---------------------------------------------------------------------------
module rgbcsc_div_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  rgbcsc_pkg::lanes_t   in_lanes,
  output logic                 out_valid,
  output rgbcsc_pkg::lanes_t   out_lanes
);
  import rgbcsc_pkg::*;

  lanes_t lanes_next;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      lanes_next[i].ds = in_lanes[i].ds >> 1;
      if (in_lanes[i].rem >= RemW'(in_lanes[i].ds)) begin
        lanes_next[i].rem = in_lanes[i].rem - RemW'(in_lanes[i].ds);
        lanes_next[i].quo = {in_lanes[i].quo[QuoW-2:0], 1'b1};
      end else begin
        lanes_next[i].rem = in_lanes[i].rem;
        lanes_next[i].quo = {in_lanes[i].quo[QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_lanes <= lanes_next;
  end

endmodule

### rtl/rgb_color_space_converter.sv
// ---------------------------------------------------------------------------
// RGB color space converter
// Pipeline: 2 set-up stages, then 9 divider stages, one quotient bit each.
// Throughput: one pixel per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous, active high; clears all valid bits, output_space = HSV.
// ---------------------------------------------------------------------------
module rgb_color_space_converter (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // first[8:0], second[15:9], third[22:16],
                                 // fourth[29:23], zero[31:30]
);
  import rgbcsc_pkg::*;

  localparam int Steps = QuoW;

  // Register file: a single register, output_space, at word 0. Byte lane
  // bits of paddr are ignored.
  logic [1:0] output_space;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, output_space} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_space <= SpaceHsv;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      output_space <= pwdata[1:0];
    end
  end

  // Global pipeline enable: every stage advances unless the output holds
  // a result the sink has not taken yet. A new pixel is taken whenever the
  // pipe advances, so a waiting result never blocks the input by itself
  // once the sink accepts.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic   prep_valid;
  lanes_t prep_lanes;

  rgbcsc_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid),
    .red          (s_tdata[7:0]),
    .green        (s_tdata[15:8]),
    .blue         (s_tdata[23:16]),
    .output_space (output_space),
    .out_valid    (prep_valid),
    .out_lanes    (prep_lanes)
  );

  // Divider chain: the divisor starts shifted left by 8 and moves right one
  // bit per stage, so each stage resolves one quotient bit MSB first.
  logic   [Steps:0] st_valid;
  lanes_t           st_lanes [Steps+1];

  assign st_valid[0] = prep_valid;
  assign st_lanes[0] = prep_lanes;

  for (genvar s = 0; s < Steps; s++) begin : g_div
    rgbcsc_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (st_valid[s]),
      .in_lanes  (st_lanes[s]),
      .out_valid (st_valid[s+1]),
      .out_lanes (st_lanes[s+1])
    );
  end

  // Last divider stage doubles as the output register.
  assign m_tvalid = st_valid[Steps];
  assign m_tdata  = {2'b00,
                     st_lanes[Steps][3].quo[6:0],
                     st_lanes[Steps][2].quo[6:0],
                     st_lanes[Steps][1].quo[6:0],
                     st_lanes[Steps][0].quo};

endmodule

### rtl/rgbcsc_checker.sv
// ---------------------------------------------------------------------------
// Converter port checker
// Port-level checks on the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "rgb_color_space_converter_defines.svh"

module rgbcsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  logic stalled;
  logic res_in_range;

  assign stalled      = m_tvalid && !m_tready;
  assign res_in_range = m_tdata[8:0] <= 9'd360 && m_tdata[15:9] <= 7'd100 &&
                        m_tdata[22:16] <= 7'd100 && m_tdata[29:23] <= 7'd100;

  // a stalled result holds
  `CSC_ASSERT_NEXT(a_hold, clk, rst, stalled, m_tvalid && $stable(m_tdata), "held result changed")

  // components stay in range
  `CSC_ASSERT_NOW(a_range, clk, rst, m_tvalid, res_in_range, "component out of range")

  // input is never back-pressured while the sink is ready
  `CSC_ASSERT_NOW(a_ready, clk, rst, m_tready, s_tready, "input stalled with ready sink")

  // nothing comes out in the cycle after reset
  `CSC_ASSERT_NOW(a_rst, clk, 1'b0, $past(rst), !m_tvalid, "result valid after reset")

endmodule

bind rgb_color_space_converter rgbcsc_checker u_rgbcsc_checker (.*);

### dv/rgb_color_space_converter_tb.sv
// ---------------------------------------------------------------------------
// RGB color space converter testbench
// Drives pixels through the stream port under all output spaces, including
// the unused code, predicts each result with exact integer rounding, and
// checks every output transfer in order against the predicted queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_color_space_converter_tb;
  import rgbcsc_pkg::*;

  localparam logic [2:0] AddrOutputSpace = 3'd0;
  localparam logic [1:0] SpaceUnused     = 2'd3;
  localparam int         PipeDepth       = 11;

  typedef struct packed {
    logic [8:0] first;
    logic [6:0] second;
    logic [6:0] third;
    logic [6:0] fourth;
  } color_t;

  // Expected-color store plus the conversion predictor.
  class color_scoreboard;
    color_t pending[$];
    logic [1:0] space;
    int errors;
    int checked;

    function new();
      space = SpaceHsv;
      errors = 0;
      checked = 0;
    endfunction

    // round(num/den), half away from zero; num >= 0
    function int unsigned rnd(int unsigned num, int unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    function int unsigned hue(int r, int g, int b, int mx, int d);
      int num;
      if (d == 0) return 0;
      if (mx == r) num = 60 * (g - b);
      else if (mx == g) num = 60 * (2 * d + b - r);
      else num = 60 * (4 * d + r - g);
      if (num < 0) num += 360 * d;
      return rnd(num, d);
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int mx, mn, d, sum, den;
      color_t c;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      c = '0;
      case (space)
        SpaceHsv: begin
          c.first = 9'(hue(r, g, b, mx, d));
          c.second = 7'((mx == 0) ? 0 : rnd(100 * d, mx));
          c.third = 7'(rnd(100 * mx, 255));
        end
        SpaceHsl: begin
          den = (sum < 510 - sum) ? sum : 510 - sum;
          c.first = 9'(hue(r, g, b, mx, d));
          c.second = 7'((sum == 0 || sum == 510) ? 0 : rnd(100 * d, den));
          c.third = 7'(rnd(100 * sum, 510));
        end
        SpaceCmyk: begin
          if (mx != 0) begin
            c.first = 9'(rnd(100 * (mx - r), mx));
            c.second = 7'(rnd(100 * (mx - g), mx));
            c.third = 7'(rnd(100 * (mx - b), mx));
          end
          c.fourth = 7'(rnd(100 * (255 - mx), 255));
        end
        default: c = '0;
      endcase
      pending.push_back(c);
    endfunction

    function void check_result(logic [31:0] data);
      color_t exp_c, act;
      act = {data[8:0], data[15:9], data[22:16], data[29:23]};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      checked++;
      if (act.first !== exp_c.first) begin
        $display("%0t: first exp %0d act %0d", $time, exp_c.first, act.first);
        errors++;
      end
      if (act.second !== exp_c.second) begin
        $display("%0t: second exp %0d act %0d", $time, exp_c.second, act.second);
        errors++;
      end
      if (act.third !== exp_c.third) begin
        $display("%0t: third exp %0d act %0d", $time, exp_c.third, act.third);
        errors++;
      end
      if (act.fourth !== exp_c.fourth) begin
        $display("%0t: fourth exp %0d act %0d", $time, exp_c.fourth, act.fourth);
        errors++;
      end
      if (data[31:30] !== 2'b00) begin
        $display("%0t: pad bits exp 0 act %b", $time, data[31:30]);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;   // first[8:0], second[15:9], third[22:16], fourth[29:23]

  color_scoreboard sb;
  int burst_left;   // pixels left in the current burst; 0 means in a gap
  int gap_left;
  int stall_mode;   // receiver pattern selector, changed per phase
  int sent;
  int space_count[4];

  rgb_color_space_converter dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Long stop: well above the worst case of ~1400 pixels with gaps and stalls.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Result side: sample on the edge, check only completed transfers.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Receiver backpressure; several patterns, including none at all.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 1) != 0);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Change output space only with the pipe drained.
  task automatic set_space(input logic [1:0] sp);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
    apb_write(AddrOutputSpace, {30'd0, sp});
    sb.space = sp;
  endtask

  // One pixel; when bursty, bursts of random length separated by random gaps. Valid
  // stays high after the transfer; the caller drops it at the end.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input bit bursty);
    if (bursty) begin
      if (burst_left == 0) begin
        gap_left = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap_left) @(posedge clk);
        end
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(r, g, b);
    space_count[sb.space]++;
    sent++;
  endtask

  task automatic directed_pixels();
    send_pixel(8'd0, 8'd0, 8'd0, 0);         // black
    send_pixel(8'd255, 8'd255, 8'd255, 0);   // white
    send_pixel(8'd128, 8'd128, 8'd128, 0);   // gray, hue 0
    send_pixel(8'd255, 8'd0, 8'd0, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 0);
    send_pixel(8'd0, 8'd0, 8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0, 0);     // red and green tie
    send_pixel(8'd0, 8'd255, 8'd255, 0);     // green and blue tie
    send_pixel(8'd255, 8'd0, 8'd255, 0);     // red and blue tie
    send_pixel(8'd255, 8'd0, 8'd1, 0);       // negative hue wraps
    send_pixel(8'd255, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd0, 8'd254, 0);     // hue 300
    send_pixel(8'd1, 8'd0, 8'd0, 0);         // tiny max
    send_pixel(8'd254, 8'd255, 8'd255, 0);   // lightness near 1
    send_pixel(8'd170, 8'd85, 8'd0, 0);
    send_pixel(8'd85, 8'd170, 8'd255, 0);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_pixels(input int n);
    int k;
    logic [7:0] r, g, b;
    for (k = 0; k < n; k++) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(0, 5))
        0: g = r;                             // red and green equal
        1: begin g = r; b = r; end            // gray
        2: r = 8'hFF;
        3: b = 8'($urandom_range(0, 3));
        default: ;
      endcase
      send_pixel(r, g, b, 1);
    end
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  initial begin
    int p, w;
    logic [1:0] order[6];
    sb = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0;
    stall_mode = 0; burst_left = 0; sent = 0;
    for (w = 0; w < 4; w++) space_count[w] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the space is HSV, so the first phase writes nothing
    directed_pixels();
    order = '{SpaceHsl, SpaceCmyk, SpaceUnused, SpaceHsv, SpaceCmyk, SpaceHsl};
    for (p = 0; p < 6; p++) begin
      set_space(order[p]);
      stall_mode = p % 4;
      directed_pixels();
      random_pixels(p == 2 ? 60 : 236);
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
    $display("Sent %0d pixels, checked %0d results under stalls and gaps",
             sent, sb.checked);
    $display("Per space HSV %0d, HSL %0d, CMYK %0d, unused code %0d",
             space_count[0], space_count[1], space_count[2], space_count[3]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
